### hdl/ss_pkg.sv
// Shared types, state codes and the gap update for the shell sorter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package ss_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned GAP_W  = 7;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_out;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_GAP,
    ST_POS,
    ST_CUR,
    ST_CMP,
    ST_PLACE,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } state_e;

  // g/3 + 1 for g below 128: g*43 >> 7 equals g/3 exactly in that range
  function automatic logic [GAP_W-1:0] gap_next(input logic [GAP_W-1:0] g);
    logic [GAP_W+5:0] prod;
    prod = {6'b0, g} * 13'd43;
    return {1'b0, prod[GAP_W+5:GAP_W]} + 7'd1;
  endfunction

endpackage

### hdl/shell_sorter.sv
// Shell sorter top level: element buffer in one synchronous RAM, sort sequencer, output register.
// Depends on ss_pkg.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------
//   in      | sink      | in_valid_i / in_stall_o | ss_pkg::in_item_t
//   out     | source    | out_valid_o / out_stall_i | ss_pkg::out_item_t
//
// Loading accepts one item per cycle; the item marked last, or the one that fills the
// buffer, closes the set and raises in_stall_o until the sorted set has been emitted.
// Each gap round passes ST_GAP, then each position ST_POS, ST_CUR and ST_CMP, with ST_CMP
// repeated per element moved, all bound by the single read and single write port of the buffer RAM.
// Emission of each result passes a RAM read, then the output register, and waits while stalled.
// Reset clears the sequencer, the fill count and the output valid; the RAM is not cleared.
`timescale 1ns / 1ps

module shell_sorter #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ss_pkg::in_item_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ss_pkg::out_item_t out_item_o
);
  import ss_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  logic signed [DATA_W-1:0] mem [MAX_LEN];
  logic signed [DATA_W-1:0] rdata_q;
  logic                     we, re;
  logic [AW-1:0]            waddr, raddr;
  logic signed [DATA_W-1:0] wdata;

  state_e                   state_q, state_d;
  logic [CW-1:0]            fill_q, fill_d;
  logic [CW-1:0]            n_q, n_d;
  logic [CW-1:0]            gap_q, gap_d;
  logic [CW-1:0]            pos_q, pos_d;
  logic [CW-1:0]            hole_q, hole_d;
  logic signed [DATA_W-1:0] cur_q, cur_d;
  logic                     out_valid_q, out_valid_d;
  out_item_t                out_item_q, out_item_d;

  logic                     in_acc, set_end, out_free, less, emit_last;
  logic [CW-1:0]            fill_inc, hole_dn, hole_dn2, gap_new;

  assign in_acc    = in_valid_i && (state_q == ST_LOAD);
  assign fill_inc  = fill_q + CW'(1);
  assign set_end   = in_item_i.is_last || (fill_inc == CW'(MAX_LEN));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign less      = cur_q < rdata_q;
  assign hole_dn   = hole_q - gap_q;
  assign hole_dn2  = hole_dn - gap_q;
  assign gap_new   = CW'(gap_next(GAP_W'(gap_q)));
  assign emit_last = (pos_q + CW'(1)) == n_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc && set_end) state_d = ST_GAP;
      end
      ST_GAP:   state_d = ST_POS;
      ST_POS: begin
        if (pos_q >= n_q) state_d = (gap_q > CW'(1)) ? ST_GAP : ST_EMIT_RD;
        else              state_d = ST_CUR;
      end
      ST_CUR:   state_d = ST_CMP;
      ST_CMP: begin
        if (less) state_d = (hole_dn >= gap_q) ? ST_CMP : ST_PLACE;
        else      state_d = ST_POS;
      end
      ST_PLACE:   state_d = ST_POS;
      ST_EMIT_RD: state_d = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (out_free) state_d = emit_last ? ST_LOAD : ST_EMIT_RD;
      end
      default:  state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    we          = 1'b0;
    re          = 1'b0;
    waddr       = hole_q[AW-1:0];
    raddr       = pos_q[AW-1:0];
    wdata       = cur_q;
    fill_d      = fill_q;
    n_d         = n_q;
    gap_d       = gap_q;
    pos_d       = pos_q;
    hole_d      = hole_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          we    = 1'b1;
          waddr = fill_q[AW-1:0];
          wdata = in_item_i.value;
          if (set_end) begin
            fill_d = '0;
            n_d    = fill_inc;
            gap_d  = fill_inc;
          end else begin
            fill_d = fill_inc;
          end
        end
      end
      ST_GAP: begin
        gap_d = gap_new;
        pos_d = gap_new;
      end
      ST_POS: begin
        if (pos_q >= n_q) begin
          if (gap_q <= CW'(1)) pos_d = '0;
        end else begin
          re     = 1'b1;
          hole_d = pos_q;
        end
      end
      ST_CUR: begin
        cur_d = rdata_q;
        re    = 1'b1;
        raddr = hole_dn[AW-1:0];
      end
      ST_CMP: begin
        we = 1'b1;
        if (less) begin
          wdata  = rdata_q;
          hole_d = hole_dn;
          re     = hole_dn >= gap_q;
          raddr  = hole_dn2[AW-1:0];
        end else begin
          pos_d = pos_q + CW'(1);
        end
      end
      ST_PLACE: begin
        we    = 1'b1;
        pos_d = pos_q + CW'(1);
      end
      ST_EMIT_RD: begin
        re = 1'b1;
      end
      ST_EMIT_WAIT: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_item_d.sorted_value = rdata_q;
          out_item_d.final_out    = emit_last;
          pos_d                   = pos_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      fill_q      <= '0;
      n_q         <= '0;
      gap_q       <= '0;
      pos_q       <= '0;
      hole_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      n_q         <= n_d;
      gap_q       <= gap_d;
      pos_q       <= pos_d;
      hole_q      <= hole_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_item_q <= out_item_d;
  end

  assign in_stall_o  = state_q != ST_LOAD;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### hdl/ss_checker.sv
// Port-level checks for the shell sorter, bound to every shell_sorter instance.
// Depends on ss_pkg and shell_sorter.
`timescale 1ns / 1ps

module ss_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input ss_pkg::in_item_t  in_item_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input ss_pkg::out_item_t out_item_o
);
  import ss_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output item changed or dropped");

  // stop taking items once an item marked last is accepted
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.is_last |=> in_stall_o)
    else $error("input not stalled after last item");

  // raise stall only after an accepted item
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall raised without an accepted item");

  // release stall only once the final result is on the output
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o && out_item_o.final_out)
    else $error("input stall released before the final result");

endmodule

bind shell_sorter ss_checker u_ss_checker (.*);

### tb/shell_sorter_tb.sv
// Self-checking testbench for shell_sorter: streams sets of signed values and
// checks every sorted item against a local sort. Depends on ss_pkg and shell_sorter.
`timescale 1ns / 1ps

module shell_sorter_tb;
  import ss_pkg::*;

  localparam int unsigned MAX_LEN     = 64;
  localparam int unsigned ITEM_TARGET = 420;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  class sort_scoreboard;
    logic signed [DATA_W-1:0] open_set[$];
    out_item_t                sorted_q[$];
    int unsigned              errors;
    int unsigned              set_limit;

    function new(int unsigned len);
      set_limit = len;
      errors    = 0;
    endfunction

    function int unsigned pending();
      return sorted_q.size();
    endfunction

    function void note_input(in_item_t it);
      logic signed [DATA_W-1:0] key;
      out_item_t                exp;
      int                       n;
      int                       i;
      int                       j;
      open_set.push_back(it.value);
      if (!it.is_last && open_set.size() < set_limit) return;
      n = open_set.size();
      for (i = 1; i < n; i++) begin
        key = open_set[i];
        j   = i - 1;
        while (j >= 0 && open_set[j] > key) begin
          open_set[j+1] = open_set[j];
          j--;
        end
        open_set[j+1] = key;
      end
      for (i = 0; i < n; i++) begin
        exp.sorted_value = open_set[i];
        exp.final_out    = (i == n - 1);
        sorted_q.push_back(exp);
      end
      open_set.delete();
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (sorted_q.size() == 0) begin
        $display("%0t: unexpected item, actual value %0d final %0b",
                 $time, got.sorted_value, got.final_out);
        errors++;
        return;
      end
      exp = sorted_q.pop_front();
      if (got.sorted_value !== exp.sorted_value) begin
        $display("%0t: sorted_value mismatch, expected %0d, actual %0d",
                 $time, exp.sorted_value, got.sorted_value);
        errors++;
      end
      if (got.final_out !== exp.final_out) begin
        $display("%0t: final_out mismatch, expected %0b, actual %0b",
                 $time, exp.final_out, got.final_out);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  sort_scoreboard sb;
  int unsigned    cycle_count;
  int unsigned    items_sent;
  bit             steady;

  shell_sorter #(
    .MAX_LEN(MAX_LEN)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value(int unsigned style);
    int unsigned r;
    r = $urandom_range(0, 9);
    case (style)
      1: return $signed($urandom_range(0, 14)) - 7;
      2: begin
        case (r)
          0, 1: return 32'sh7fffffff;
          2, 3: return 32'sh80000000;
          4: return 0;
          5: return -1;
          6: return 1;
          default: return $urandom;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic signed [DATA_W-1:0] v, input logic last);
    int unsigned idle;
    in_item_t    it;
    idle         = idle_len();
    it.value     = v;
    it.is_last   = last;
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic send_set(input int unsigned len, input logic fill_last);
    int unsigned style;
    int unsigned i;
    style  = $urandom_range(0, 2);
    steady = ($urandom_range(0, 4) == 0);
    for (i = 0; i < len; i++) begin
      if (i == len - 1) send_item(pick_value(style), (len == MAX_LEN) ? fill_last : 1'b1);
      else send_item(pick_value(style), 1'b0);
    end
  endtask

  initial begin
    int unsigned r;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(10, 80)) @(posedge clk);
      end else if (r < 90) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned r;
    int unsigned len;
    sb          = new(MAX_LEN);
    cycle_count = 0;
    items_sent  = 0;
    steady      = 1'b0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_item    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes and duplicates of the extremes
    send_item(32'sh7fffffff, 1'b0);
    send_item(32'sh80000000, 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(1, 1'b0);
    send_item(32'sh7fffffff, 1'b0);
    send_item(32'sh80000000, 1'b1);
    // single element set
    send_item(-5, 1'b1);
    // equal values
    send_item(3, 1'b0);
    send_item(3, 1'b0);
    send_item(3, 1'b0);
    send_item(3, 1'b1);
    // reversed pair, then an already sorted run
    send_item(100, 1'b0);
    send_item(-100, 1'b1);
    send_item(1, 1'b0);
    send_item(2, 1'b0);
    send_item(3, 1'b0);
    send_item(4, 1'b0);
    send_item(5, 1'b1);

    // full buffer closes the set with and without the last mark
    send_set(MAX_LEN, 1'b0);
    send_set(MAX_LEN, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 6) len = MAX_LEN;
      else if (r < 9) len = MAX_LEN - 1;
      else if (r < 15) len = $urandom_range(13, 40);
      else len = $urandom_range(1, 12);
      send_set(len, $urandom_range(0, 1));
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
